FILE: rtl/ramped_pulse_train_generator_assert.svh
// assertion macros for the ramped pulse train generator
`ifndef RAMPED_PULSE_TRAIN_GENERATOR_ASSERT_SVH
`define RAMPED_PULSE_TRAIN_GENERATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RPTG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RPTG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rptg_pkg.sv
package rptg_pkg;

    localparam int TIME_BITS = 20;
    localparam logic [31:0] TIME_MAX = 32'((64'd1 << TIME_BITS) - 64'd1);

    localparam int IDX_BITS = 9;
    localparam int PROD_BITS = 25;
    localparam int RAMP_BITS = 26;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 20;

    // register indexes on the config port
    localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH_STEP   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PULSE_GAP    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PULSE_COUNT  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_EXTRA_PULSES = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_BLOCK_GAP    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_SYNC_WIDTH   = 3'd6;

    // register reset values
    localparam logic [19:0] RST_FIRST_WIDTH  = 20'd400;
    localparam logic [15:0] RST_WIDTH_STEP   = 16'd50;
    localparam logic [19:0] RST_PULSE_GAP    = 20'd100;
    localparam logic [7:0]  RST_PULSE_COUNT  = 8'd10;
    localparam logic [2:0]  RST_EXTRA_PULSES = 3'd3;
    localparam logic [19:0] RST_BLOCK_GAP    = 20'd3000;
    localparam logic [15:0] RST_SYNC_WIDTH   = 16'd50;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SYNC,
        PH_HIGH,
        PH_LOW,
        PH_GAP
    } phase_t;

    typedef struct packed {
        logic [19:0] first_width;
        logic [15:0] width_step;
        logic [19:0] pulse_gap;
        logic [7:0]  pulse_count;
        logic [2:0]  extra_pulses;
        logic [19:0] block_gap;
        logic [15:0] sync_width;
    } cfg_t;

    typedef struct packed {
        logic enable_switch_n;
        logic mode_switch_n;
    } item_t;

    typedef struct packed {
        logic signal_a;
        logic signal_b;
        logic alt_mode_on;
        logic block_end;
    } result_t;

    // clamp to the tick counter range
    function automatic logic [TIME_BITS-1:0] sat_time(input logic [31:0] v);
        if (v > TIME_MAX)
        begin
            return TIME_MAX[TIME_BITS-1:0];
        end
        return v[TIME_BITS-1:0];
    endfunction

    // clamp, and a zero length still lasts one tick
    function automatic logic [TIME_BITS-1:0] duration(input logic [31:0] v);
        if (v == 32'd0)
        begin
            return {{(TIME_BITS-1){1'b0}}, 1'b1};
        end
        return sat_time(v);
    endfunction

endpackage

FILE: rtl/ramped_pulse_train_generator.sv
// a tick transaction accepted into the input register moves on to the result register, which
// drives m_tvalid and holds its level transaction while the master side stalls
// throughput: one tick transaction per clock, sustained while the master side keeps up
// the tick state machine updates once per accepted tick and does not limit the rate
// reset (rst_n low, asynchronous): idle between blocks, counters cleared, default mode,
// both stages empty, registers back to their defaults
module ramped_pulse_train_generator
    import rptg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // tick stream in
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,   // enable_switch_n, mode_switch_n, zero pad
    // level stream out
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [7:0]               m_tdata,   // signal_a, signal_b, alt_mode_on, zero pad
    output logic                     m_tlast,   // block_end
    // register writes
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

`include "ramped_pulse_train_generator_assert.svh"

    cfg_t    cfg;
    item_t   item;
    logic    item_valid;
    logic    out_ready;
    logic    advance;
    result_t result;

    // a tick moves from the input register to the result register
    // whenever the result register is free or being drained
    assign advance = item_valid && out_ready;

    // live configuration registers, read by the state machine every tick
    rptg_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register, keeps taking transactions while the pipe moves
    rptg_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .pop        (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // phase / tick counter / pulse ramp state machine, one step per tick
    rptg_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item),
        .cfg    (cfg),
        .result (result)
    );

    // result register toward the master side
    rptg_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .result    (result),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // sync pulse and train never overlap
    `RPTG_ASSERT_NOW(a_ab_exclusive, m_tvalid, !(m_tdata[0] && m_tdata[1]), "a and b both high")
    // input side only stalls behind a full, stalled result register
    `RPTG_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid && !m_tready, "unexpected input stall")
    // a held tick always moves on once the output drains
    `RPTG_ASSERT_NEXT(a_drain, !s_tready && m_tready, s_tready || m_tvalid, "no advance on drain")

endmodule

FILE: rtl/rptg_cfg_regs.sv
module rptg_cfg_regs
    import rptg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_width  <= RST_FIRST_WIDTH;
            cfg_reg.width_step   <= RST_WIDTH_STEP;
            cfg_reg.pulse_gap    <= RST_PULSE_GAP;
            cfg_reg.pulse_count  <= RST_PULSE_COUNT;
            cfg_reg.extra_pulses <= RST_EXTRA_PULSES;
            cfg_reg.block_gap    <= RST_BLOCK_GAP;
            cfg_reg.sync_width   <= RST_SYNC_WIDTH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FIRST_WIDTH:  cfg_reg.first_width  <= cfg_data[19:0];
                REG_WIDTH_STEP:   cfg_reg.width_step   <= cfg_data[15:0];
                REG_PULSE_GAP:    cfg_reg.pulse_gap    <= cfg_data[19:0];
                REG_PULSE_COUNT:  cfg_reg.pulse_count  <= cfg_data[7:0];
                REG_EXTRA_PULSES: cfg_reg.extra_pulses <= cfg_data[2:0];
                REG_BLOCK_GAP:    cfg_reg.block_gap    <= cfg_data[19:0];
                REG_SYNC_WIDTH:   cfg_reg.sync_width   <= cfg_data[15:0];
                default:          ; // unknown index, dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/rptg_in_stage.sv
module rptg_in_stage
    import rptg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       pop,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    assign s_tready = !valid_reg || pop;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.enable_switch_n <= s_tdata[0];
            item_reg.mode_switch_n   <= s_tdata[1];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: rtl/rptg_core.sv
module rptg_core
    import rptg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    phase_t                phase_reg,       phase_next;
    logic [TIME_BITS-1:0]  tick_left_reg,   tick_left_next;
    logic [IDX_BITS-1:0]   pulse_index_reg, pulse_index_next;
    logic                  alt_mode_reg,    alt_mode_next;
    logic                  mode_held_reg,   mode_held_next;

    logic                  start;
    logic                  alt_eff;
    phase_t                phase_eff;
    logic [TIME_BITS-1:0]  tick_eff;
    logic [TIME_BITS-1:0]  tick_dec;
    logic                  done;
    logic [IDX_BITS-1:0]   total;
    logic [IDX_BITS-1:0]   idx_base;
    logic [IDX_BITS-1:0]   idx_inc;
    logic [IDX_BITS-1:0]   ramp_idx;
    logic [PROD_BITS-1:0]  ramp_prod;
    logic [RAMP_BITS-1:0]  ramp_sum;
    logic [TIME_BITS-1:0]  ramp_width;
    logic                  more;
    logic                  gap_zero;

    // view of the state for this tick, idle start folded in
    always_comb
    begin
        start     = (phase_reg == PH_IDLE) && !item.enable_switch_n;
        alt_eff   = alt_mode_reg ^ (start && !item.mode_switch_n && !mode_held_reg);
        phase_eff = start ? PH_SYNC : phase_reg;
        tick_eff  = start ? duration(32'(cfg.sync_width)) : tick_left_reg;
        tick_dec  = (tick_eff != '0) ? tick_eff - {{(TIME_BITS-1){1'b0}}, 1'b1} : '0;
        done      = (tick_dec == '0);
        total     = {1'b0, cfg.pulse_count}
                  + (alt_eff ? {{(IDX_BITS-3){1'b0}}, cfg.extra_pulses} : '0);
        idx_base  = start ? '0 : pulse_index_reg;
        idx_inc   = idx_base + {{(IDX_BITS-1){1'b0}}, 1'b1};
        ramp_idx  = (phase_eff == PH_SYNC) ? '0 : idx_inc;
        ramp_prod = PROD_BITS'(ramp_idx) * PROD_BITS'(cfg.width_step);
        ramp_sum  = RAMP_BITS'(cfg.first_width) + RAMP_BITS'(ramp_prod);
        ramp_width = duration(32'(ramp_sum));
        more      = (phase_eff == PH_SYNC) ? (total != '0) : (idx_inc < total);
        gap_zero  = (cfg.block_gap == 20'd0);
    end

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        tick_left_next   = tick_left_reg;
        pulse_index_next = pulse_index_reg;
        alt_mode_next    = alt_mode_reg;
        mode_held_next   = mode_held_reg;
        if (phase_eff != PH_IDLE)
        begin
            alt_mode_next    = alt_eff;
            if (start)
            begin
                mode_held_next = !item.mode_switch_n;
            end
            phase_next       = phase_eff;
            tick_left_next   = tick_dec;
            pulse_index_next = idx_base;
            if (done)
            begin
                case (phase_eff)
                    PH_SYNC, PH_LOW:
                    begin
                        pulse_index_next = ramp_idx;
                        if (more)
                        begin
                            phase_next     = PH_HIGH;
                            tick_left_next = ramp_width;
                        end
                        else if (gap_zero)
                        begin
                            phase_next     = PH_IDLE;
                            tick_left_next = '0;
                        end
                        else
                        begin
                            phase_next     = PH_GAP;
                            tick_left_next = sat_time(32'(cfg.block_gap));
                        end
                    end
                    PH_HIGH:
                    begin
                        phase_next     = PH_LOW;
                        tick_left_next = duration(32'(cfg.pulse_gap));
                    end
                    default:
                    begin
                        phase_next     = PH_IDLE;
                        tick_left_next = '0;
                    end
                endcase
            end
        end
    end

    // outputs for this tick
    always_comb
    begin
        result.signal_a    = (phase_eff == PH_HIGH);
        result.signal_b    = (phase_eff == PH_SYNC);
        result.alt_mode_on = alt_eff;
        result.block_end   = done && ((phase_eff == PH_GAP)
                           || (gap_zero && !more
                               && ((phase_eff == PH_SYNC) || (phase_eff == PH_LOW))));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            tick_left_reg   <= '0;
            pulse_index_reg <= '0;
            alt_mode_reg    <= 1'b0;
            mode_held_reg   <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg       <= phase_next;
            tick_left_reg   <= tick_left_next;
            pulse_index_reg <= pulse_index_next;
            alt_mode_reg    <= alt_mode_next;
            mode_held_reg   <= mode_held_next;
        end
    end

endmodule

FILE: rtl/rptg_out_stage.sv
module rptg_out_stage
    import rptg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  result_t    result,
    output logic       out_ready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign out_ready = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'b0, result_reg.alt_mode_on, result_reg.signal_b, result_reg.signal_a};
    assign m_tlast  = result_reg.block_end;

endmodule
